// ===== rtl/core/rosc_pkg.sv =====
// Shared types, constants and helpers for the opponent seek controller.
package rosc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned DRIVE_W    = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SPEED_W-1:0] ESCAPE_BACK_DRIVE = 8'd200;
  localparam logic [SPEED_W-1:0] ESCAPE_TURN_DRIVE = 8'd200;
  localparam logic [SPEED_W-1:0] TRACK_SLOW_DRIVE  = 8'd100;
  localparam logic [SPEED_W-1:0] TRACK_FAST_DRIVE  = 8'd220;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAM_DISTANCE   = 3'd0,
    CFG_TRACK_DISTANCE = 3'd1,
    CFG_BACK_TIME      = 3'd2,
    CFG_TURN_TIME      = 3'd3,
    CFG_LOCK_WINDOW    = 3'd4,
    CFG_SEARCH_PERIOD  = 3'd5,
    CFG_CHARGE_DRIVE   = 3'd6,
    CFG_SPIN_DRIVE     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PHASE_NONE = 2'd0,
    PHASE_BACK = 2'd1,
    PHASE_TURN = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [DIST_W-1:0] dist_front;
    logic [DIST_W-1:0] dist_left;
    logic [DIST_W-1:0] dist_right;
    logic              line_left;
    logic              line_right;
  } sample_t;

  typedef struct packed {
    logic [DIST_W-1:0]  ram_distance;
    logic [DIST_W-1:0]  track_distance;
    logic [DIST_W-1:0]  back_time;
    logic [DIST_W-1:0]  turn_time;
    logic [DIST_W-1:0]  lock_window;
    logic [DIST_W-1:0]  search_period;
    logic [SPEED_W-1:0] charge_drive;
    logic [SPEED_W-1:0] spin_drive;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ram_distance:   16'd200,
    track_distance: 16'd300,
    back_time:      16'd300,
    turn_time:      16'd250,
    lock_window:    16'd500,
    search_period:  16'd1000,
    charge_drive:   8'd255,
    spin_drive:     8'd120
  };

  typedef struct packed {
    phase_e            escape_phase;
    logic              escape_turn_left;
    logic [TIME_W-1:0] escape_start;
    side_e             last_side;
    logic [TIME_W-1:0] target_seen_time;
    logic              search_spin_right;
    logic [TIME_W-1:0] search_start;
  } ctl_state_t;

  localparam ctl_state_t STATE_RESET = '{
    escape_phase:      PHASE_NONE,
    escape_turn_left:  1'b0,
    escape_start:      '0,
    last_side:         SIDE_NONE,
    target_seen_time:  '0,
    search_spin_right: 1'b0,
    search_start:      '0
  };

  function automatic drive_t drive_pos(logic [SPEED_W-1:0] mag);
    return drive_t'({1'b0, mag});
  endfunction

  function automatic drive_t drive_neg(logic [SPEED_W-1:0] mag);
    return drive_t'({DRIVE_W{1'b0}} - {1'b0, mag});
  endfunction

endpackage

// ===== rtl/core/rosc_sample_if.sv =====
// Sensor sample channel: valid/ready handshake with the sample fields.
interface rosc_sample_if;
  logic                      valid;
  logic                      ready;
  logic [rosc_pkg::TIME_W-1:0] now_ms;
  logic [rosc_pkg::DIST_W-1:0] dist_front;
  logic [rosc_pkg::DIST_W-1:0] dist_left;
  logic [rosc_pkg::DIST_W-1:0] dist_right;
  logic                      line_left;
  logic                      line_right;

  modport source (
    output valid, now_ms, dist_front, dist_left, dist_right, line_left, line_right,
    input  ready
  );
  modport sink (
    input  valid, now_ms, dist_front, dist_left, dist_right, line_left, line_right,
    output ready
  );
endinterface

// ===== rtl/core/rosc_drive_if.sv =====
// Wheel drive channel: valid/ready handshake with signed left and right drive.
interface rosc_drive_if;
  logic                                valid;
  logic                                ready;
  logic signed [rosc_pkg::DRIVE_W-1:0] left_drive;
  logic signed [rosc_pkg::DRIVE_W-1:0] right_drive;

  modport source (
    output valid, left_drive, right_drive,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive,
    output ready
  );
endinterface

// ===== rtl/core/rosc_decide.sv =====
// Mode decision for one sample: next controller state and drive result.
module rosc_decide (
  input  rosc_pkg::cfg_t       cfg_i,
  input  rosc_pkg::ctl_state_t state_i,
  input  rosc_pkg::sample_t    sample_i,
  output rosc_pkg::ctl_state_t state_o,
  output logic                 emit_o,
  output rosc_pkg::drive_t     left_o,
  output rosc_pkg::drive_t     right_o
);
  import rosc_pkg::*;

  logic [TIME_W-1:0] esc_elapsed;
  logic [TIME_W-1:0] tgt_elapsed;
  logic [TIME_W-1:0] srch_elapsed;

  assign esc_elapsed  = sample_i.now_ms - state_i.escape_start;
  assign tgt_elapsed  = sample_i.now_ms - state_i.target_seen_time;
  assign srch_elapsed = sample_i.now_ms - state_i.search_start;

  always_comb begin
    logic spin;
    logic locked;
    spin    = state_i.search_spin_right;
    locked  = 1'b0;
    state_o = state_i;
    emit_o  = 1'b1;
    left_o  = '0;
    right_o = '0;
    case (state_i.escape_phase)
      PHASE_BACK: begin
        left_o  = drive_neg(ESCAPE_BACK_DRIVE);
        right_o = drive_neg(ESCAPE_BACK_DRIVE);
        if (esc_elapsed >= TIME_W'(cfg_i.back_time)) begin
          state_o.escape_start = sample_i.now_ms;
          state_o.escape_phase = PHASE_TURN;
        end
      end
      PHASE_TURN: begin
        if (esc_elapsed >= TIME_W'(cfg_i.turn_time)) begin
          state_o.escape_phase = PHASE_NONE;
        end
        if (state_i.escape_turn_left) begin
          left_o  = drive_pos(ESCAPE_TURN_DRIVE);
          right_o = drive_neg(ESCAPE_BACK_DRIVE);
        end else begin
          left_o  = drive_neg(ESCAPE_BACK_DRIVE);
          right_o = drive_pos(ESCAPE_TURN_DRIVE);
        end
      end
      default: begin
        if (sample_i.line_left || sample_i.line_right) begin
          // edge seen: start reversing and hold the drive
          state_o.escape_phase     = PHASE_BACK;
          state_o.escape_start     = sample_i.now_ms;
          state_o.escape_turn_left = sample_i.line_left;
          emit_o                   = 1'b0;
        end else if (sample_i.dist_front < cfg_i.ram_distance) begin
          state_o.last_side        = SIDE_NONE;
          state_o.target_seen_time = sample_i.now_ms;
          left_o                   = drive_pos(cfg_i.charge_drive);
          right_o                  = drive_pos(cfg_i.charge_drive);
        end else if (sample_i.dist_left < cfg_i.track_distance) begin
          state_o.last_side        = SIDE_LEFT;
          state_o.target_seen_time = sample_i.now_ms;
          left_o                   = drive_pos(TRACK_SLOW_DRIVE);
          right_o                  = drive_pos(TRACK_FAST_DRIVE);
        end else if (sample_i.dist_right < cfg_i.track_distance) begin
          state_o.last_side        = SIDE_RIGHT;
          state_o.target_seen_time = sample_i.now_ms;
          left_o                   = drive_pos(TRACK_FAST_DRIVE);
          right_o                  = drive_pos(TRACK_SLOW_DRIVE);
        end else begin
          locked = (tgt_elapsed <= TIME_W'(cfg_i.lock_window)) &&
                   (state_i.last_side == SIDE_LEFT || state_i.last_side == SIDE_RIGHT);
          if (locked) begin
            if (state_i.last_side == SIDE_LEFT) begin
              left_o  = drive_neg(cfg_i.spin_drive);
              right_o = drive_pos(cfg_i.spin_drive);
            end else begin
              left_o  = drive_pos(cfg_i.spin_drive);
              right_o = drive_neg(cfg_i.spin_drive);
            end
          end else begin
            if (srch_elapsed >= TIME_W'(cfg_i.search_period)) begin
              spin                      = ~state_i.search_spin_right;
              state_o.search_spin_right = spin;
              state_o.search_start      = sample_i.now_ms;
            end
            if (spin) begin
              left_o  = drive_pos(cfg_i.spin_drive);
              right_o = drive_neg(cfg_i.spin_drive);
            end else begin
              left_o  = drive_neg(cfg_i.spin_drive);
              right_o = drive_pos(cfg_i.spin_drive);
            end
          end
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/robot_opponent_seek_controller.sv =====
// Opponent seek controller: sample register, mode decision, drive result register.
// A sample passes the sample register and then the drive result register.
// The decision is combinational; mode state updates as the held sample advances.
// Throughput: one sample per cycle unless a held drive result stalls the input.
// Outside an escape, an edge line sample gives no result; the drive output holds.
// Reset clears the mode state and loads the register defaults; no clearing pass.
module robot_opponent_seek_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rosc_sample_if.sink                        sample,
  rosc_drive_if.source                       drive,
  input  logic                               cfg_we_i,
  input  logic [rosc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rosc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import rosc_pkg::*;

  cfg_t       cfg_q;
  ctl_state_t state_q;
  ctl_state_t state_d;
  sample_t    in_q;
  logic       in_vld_q;
  logic       out_vld_q;
  drive_t     left_q;
  drive_t     right_q;
  drive_t     left_d;
  drive_t     right_d;
  logic       emit;
  logic       adv;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RAM_DISTANCE:   cfg_q.ram_distance   <= cfg_wdata_i;
        CFG_TRACK_DISTANCE: cfg_q.track_distance <= cfg_wdata_i;
        CFG_BACK_TIME:      cfg_q.back_time      <= cfg_wdata_i;
        CFG_TURN_TIME:      cfg_q.turn_time      <= cfg_wdata_i;
        CFG_LOCK_WINDOW:    cfg_q.lock_window    <= cfg_wdata_i;
        CFG_SEARCH_PERIOD:  cfg_q.search_period  <= cfg_wdata_i;
        CFG_CHARGE_DRIVE:   cfg_q.charge_drive   <= cfg_wdata_i[SPEED_W-1:0];
        CFG_SPIN_DRIVE:     cfg_q.spin_drive     <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  rosc_decide u_decide (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .sample_i(in_q),
    .state_o (state_d),
    .emit_o  (emit),
    .left_o  (left_d),
    .right_o (right_d)
  );

  // advance the held sample unless its result has nowhere to go
  assign adv          = in_vld_q && (!emit || !out_vld_q || drive.ready);
  assign sample.ready = !in_vld_q || adv;
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.now_ms     <= sample.now_ms;
      in_q.dist_front <= sample.dist_front;
      in_q.dist_left  <= sample.dist_left;
      in_q.dist_right <= sample.dist_right;
      in_q.line_left  <= sample.line_left;
      in_q.line_right <= sample.line_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (drive.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign drive.valid       = out_vld_q;
  assign drive.left_drive  = left_q;
  assign drive.right_drive = right_q;

endmodule

// ===== rtl/core/rosc_checker.sv =====
// Port-level checks for the opponent seek controller, bound to the top level.
module rosc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [rosc_pkg::DRIVE_W-1:0] left_drive_i,
  input logic [rosc_pkg::DRIVE_W-1:0] right_drive_i
);
  import rosc_pkg::*;

  localparam logic [DRIVE_W-1:0] DRIVE_MIN_CODE = {1'b1, {(DRIVE_W-1){1'b0}}};

  // a stalled result holds its values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_drive_i) &&
    $stable(right_drive_i))
    else $error("stalled drive result changed");

  // with the result register empty, the sample side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("sample ready low with empty result register");

  // a new result follows an earlier sample transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("drive result without a matching sample");

  // drive magnitudes stay within 255
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> left_drive_i != DRIVE_MIN_CODE && right_drive_i != DRIVE_MIN_CODE)
    else $error("drive value out of range");

endmodule

bind robot_opponent_seek_controller rosc_checker u_rosc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample.valid),
  .in_ready_i   (sample.ready),
  .out_valid_i  (drive.valid),
  .out_ready_i  (drive.ready),
  .left_drive_i (drive.left_drive),
  .right_drive_i(drive.right_drive)
);

// ===== tb/sv/rosc_seek_check_pkg.sv =====
`timescale 1ns / 1ps
// Drive predictor and result scoreboard for the opponent seek controller testbench.
package rosc_seek_check_pkg;
  import rosc_pkg::*;

  typedef struct packed {
    drive_t left;
    drive_t right;
  } drive_pair_t;

  class seek_scoreboard;
    cfg_t          regs;
    phase_e        esc_phase;
    bit            esc_turn_left;
    logic [31:0]   esc_since;
    side_e         seen_side;
    logic [31:0]   seen_ms;
    bit            spin_cw;
    logic [31:0]   flip_ms;
    drive_pair_t   due_drives[$];
    int unsigned   mismatches;

    function new();
      regs          = CFG_RESET;
      esc_phase     = PHASE_NONE;
      esc_turn_left = 1'b0;
      esc_since     = '0;
      seen_side     = SIDE_NONE;
      seen_ms       = '0;
      spin_cw       = 1'b0;
      flip_ms       = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_RAM_DISTANCE:   regs.ram_distance   = value;
        CFG_TRACK_DISTANCE: regs.track_distance = value;
        CFG_BACK_TIME:      regs.back_time      = value;
        CFG_TURN_TIME:      regs.turn_time      = value;
        CFG_LOCK_WINDOW:    regs.lock_window    = value;
        CFG_SEARCH_PERIOD:  regs.search_period  = value;
        CFG_CHARGE_DRIVE:   regs.charge_drive   = value[7:0];
        CFG_SPIN_DRIVE:     regs.spin_drive     = value[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_drives.size();
    endfunction

    function void push_drive(int l, int r);
      drive_pair_t p;
      p.left  = l[8:0];
      p.right = r[8:0];
      due_drives.push_back(p);
    endfunction

    // Advance the mode state by one accepted sample and queue the drive it causes.
    function void note_sample(sample_t s);
      logic [31:0] age;
      int          spin;
      int          back;
      int          turn;
      int          slow;
      int          fast;
      spin = int'(regs.spin_drive);
      back = int'(ESCAPE_BACK_DRIVE);
      turn = int'(ESCAPE_TURN_DRIVE);
      slow = int'(TRACK_SLOW_DRIVE);
      fast = int'(TRACK_FAST_DRIVE);

      if (esc_phase == PHASE_BACK) begin
        age = s.now_ms - esc_since;
        if (age >= regs.back_time) begin
          esc_since = s.now_ms;
          esc_phase = PHASE_TURN;
        end
        push_drive(-back, -back);
        return;
      end
      if (esc_phase == PHASE_TURN) begin
        age = s.now_ms - esc_since;
        if (age >= regs.turn_time) esc_phase = PHASE_NONE;
        if (esc_turn_left) push_drive(turn, -back);
        else push_drive(-back, turn);
        return;
      end

      // Edge line seen: start reversing, no drive update.
      if (s.line_left || s.line_right) begin
        esc_phase     = PHASE_BACK;
        esc_since     = s.now_ms;
        esc_turn_left = s.line_left;
        return;
      end

      if (s.dist_front < regs.ram_distance) begin
        seen_side = SIDE_NONE;
        seen_ms   = s.now_ms;
        push_drive(int'(regs.charge_drive), int'(regs.charge_drive));
        return;
      end
      if (s.dist_left < regs.track_distance) begin
        seen_side = SIDE_LEFT;
        seen_ms   = s.now_ms;
        push_drive(slow, fast);
        return;
      end
      if (s.dist_right < regs.track_distance) begin
        seen_side = SIDE_RIGHT;
        seen_ms   = s.now_ms;
        push_drive(fast, slow);
        return;
      end

      age = s.now_ms - seen_ms;
      if (age <= regs.lock_window) begin
        if (seen_side == SIDE_LEFT) begin
          push_drive(-spin, spin);
          return;
        end
        if (seen_side == SIDE_RIGHT) begin
          push_drive(spin, -spin);
          return;
        end
      end

      age = s.now_ms - flip_ms;
      if (age >= regs.search_period) begin
        spin_cw = !spin_cw;
        flip_ms = s.now_ms;
      end
      if (spin_cw) push_drive(spin, -spin);
      else push_drive(-spin, spin);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_drive(drive_t l, drive_t r);
      drive_pair_t want;
      if (due_drives.size() == 0) begin
        report($sformatf("drive %0d/%0d with none pending", l, r));
        return;
      end
      want = due_drives.pop_front();
      if (l !== want.left)
        report($sformatf("left_drive %0d, predicted %0d", l, want.left));
      if (r !== want.right)
        report($sformatf("right_drive %0d, predicted %0d", r, want.right));
    endtask
  endclass

endpackage

// ===== tb/sv/robot_opponent_seek_controller_test.sv =====
`timescale 1ns / 1ps
// Top-level testbench: drives samples and register writes, checks drive results.
module robot_opponent_seek_controller_test;
  import rosc_pkg::*;
  import rosc_seek_check_pkg::*;

  localparam int          LATENCY     = 2;
  localparam int          LONG_STALL  = 60;
  localparam int          PHASES      = 8;
  localparam int          PHASE_LEN   = 204;
  localparam int          STALL_PHASE = 4;
  localparam logic [15:0] FAR         = 16'hFFFF;

  typedef enum {REGS_NEAR, REGS_ZERO, REGS_MAX, REGS_WIDE} regs_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rosc_sample_if sample_ch ();
  rosc_drive_if  drive_ch ();

  robot_opponent_seek_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample      (sample_ch),
    .drive       (drive_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  seek_scoreboard sb = new();
  sample_t        taken;
  logic [31:0]    clock_ms;
  bit             src_steady;
  bit             sink_steady;
  bit             stall_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  function automatic logic [15:0] pick_dist(logic [15:0] limit, int below_pct);
    if (limit != 0 && $urandom_range(0, 99) < below_pct)
      return 16'($urandom_range(0, limit - 16'd1));
    case ($urandom_range(0, 9))
      0: return FAR;
      1: return limit;
      2: return limit + 16'd1;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near_value(cfg_idx_e idx);
    case (idx)
      CFG_RAM_DISTANCE:   return 16'($urandom_range(50, 2000));
      CFG_TRACK_DISTANCE: return 16'($urandom_range(50, 3000));
      CFG_CHARGE_DRIVE,
      CFG_SPIN_DRIVE:     return 16'($urandom_range(0, 255));
      default:            return 16'($urandom_range(0, 600));
    endcase
  endfunction

  // Score transactions on both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sample_ch.valid && sample_ch.ready) begin
        taken = {sample_ch.now_ms, sample_ch.dist_front, sample_ch.dist_left,
                 sample_ch.dist_right, sample_ch.line_left, sample_ch.line_right};
        sb.note_sample(taken);
      end
      if (drive_ch.valid && drive_ch.ready)
        sb.check_drive(drive_ch.left_drive, drive_ch.right_drive);
    end
  end

  // Result receiver: random holds, plus one long hold on request.
  initial begin : drive_sink
    int hold;
    int tick;
    hold = 0;
    tick = 0;
    drive_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 64 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      if (hold == 0 && stall_req) begin
        stall_req = 1'b0;
        hold      = LONG_STALL;
      end
      if (hold > 0) begin
        drive_ch.ready <= 1'b0;
        hold--;
      end else begin
        drive_ch.ready <= 1'b1;
        hold = pick_gap(sink_steady);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic offer(input logic [31:0] ms, input logic [15:0] front, left, right,
                       input bit ll, lr);
    int gap;
    sample_ch.valid      <= 1'b1;
    sample_ch.now_ms     <= ms;
    sample_ch.dist_front <= front;
    sample_ch.dist_left  <= left;
    sample_ch.dist_right <= right;
    sample_ch.line_left  <= ll;
    sample_ch.line_right <= lr;
    do @(posedge clk_i); while (sample_ch.ready !== 1'b1);
    @(negedge clk_i);
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait out every pending drive plus any in-flight line sample.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);
  endtask

  task automatic program_regs(regs_mode_e mode);
    cfg_idx_e    idx;
    logic [15:0] value;
    idx = idx.first();
    do begin
      case (mode)
        REGS_ZERO: value = 16'h0000;
        REGS_MAX:  value = 16'hFFFF;
        REGS_WIDE: value = 16'($urandom);
        default:   value = near_value(idx);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= value;
      sb.write_reg(idx, value);
      @(negedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_sample();
    logic [31:0] span;
    logic [15:0] front;
    logic [15:0] left;
    logic [15:0] right;
    bit          ll;
    bit          lr;
    int          line_pct;
    int          sides;
    span = 32'(sb.regs.back_time);
    if (sb.regs.turn_time > span) span = 32'(sb.regs.turn_time);
    if (sb.regs.lock_window > span) span = 32'(sb.regs.lock_window);
    if (sb.regs.search_period > span) span = 32'(sb.regs.search_period);
    span = span / 3 + 4;
    if ($urandom_range(0, 99) < 2) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, span);

    // Line flags during an escape are noise; otherwise they start one.
    line_pct = (sb.esc_phase != PHASE_NONE) ? 30 : 7;
    ll = 1'b0;
    lr = 1'b0;
    if ($urandom_range(0, 99) < line_pct) begin
      sides = $urandom_range(1, 3);
      ll    = sides[1];
      lr    = sides[0];
    end
    front = pick_dist(sb.regs.ram_distance, 20);
    left  = pick_dist(sb.regs.track_distance, 25);
    right = pick_dist(sb.regs.track_distance, 25);
    offer(clock_ms, front, left, right, ll, lr);
  endtask

  task automatic run_directed();
    offer(32'd10, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd1000, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd1001, 16'd199, FAR, FAR, 1'b0, 1'b0);
    offer(32'd1002, 16'd200, 16'd299, FAR, 1'b0, 1'b0);
    offer(32'd1003, 16'd200, 16'd300, 16'd299, 1'b0, 1'b0);
    // lock window is inclusive at its far end
    offer(32'd1503, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd1504, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd1505, FAR, FAR, FAR, 1'b1, 1'b0);
    offer(32'd1700, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
    offer(32'd1805, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd1900, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd2055, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd2056, FAR, FAR, FAR, 1'b0, 1'b1);
    offer(32'd2356, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd2606, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd2607, FAR, FAR, FAR, 1'b1, 1'b1);
    offer(32'd2907, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd3157, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'd3158, FAR, 16'd0, FAR, 1'b0, 1'b0);
    // ram forgets the side, so no lock follows
    offer(32'd3159, 16'd0, FAR, FAR, 1'b0, 1'b0);
    offer(32'd3160, FAR, FAR, FAR, 1'b0, 1'b0);
    // lock, search flip and escape across the timestamp wrap
    offer(32'hFFFF_FFF0, FAR, FAR, 16'd0, 1'b0, 1'b0);
    offer(32'h0000_01E0, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'h0000_01E5, FAR, FAR, FAR, 1'b0, 1'b0);
    offer(32'hFFFF_FF00, FAR, FAR, FAR, 1'b1, 1'b0);
    offer(32'h0000_002C, FAR, FAR, FAR, 1'b0, 1'b0);
  endtask

  initial begin : stimulus
    regs_mode_e mode;
    sample_ch.valid      = 1'b0;
    sample_ch.now_ms     = '0;
    sample_ch.dist_front = '0;
    sample_ch.dist_left  = '0;
    sample_ch.dist_right = '0;
    sample_ch.line_left  = 1'b0;
    sample_ch.line_right = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_RAM_DISTANCE;
    cfg_wdata_i          = '0;
    rst_ni               = 1'b0;
    clock_ms             = '0;
    src_steady           = 1'b0;
    sink_steady          = 1'b0;
    stall_req            = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 1) mode = REGS_ZERO;
      else if (p == 2) mode = REGS_MAX;
      else if (p % 2 == 1) mode = REGS_WIDE;
      else mode = REGS_NEAR;
      program_regs(mode);
      clock_ms = $urandom;
      if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i % 50 == 0) src_steady = ($urandom_range(0, 3) == 0);
        // Hold off the receiver while the sender keeps offering back to back.
        if (p == STALL_PHASE && i == PHASE_LEN / 2) begin
          stall_req  = 1'b1;
          src_steady = 1'b1;
        end
        random_sample();
      end
      settle();
    end

    if (sb.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
